[rtl/amt_pkg.sv]
package amt_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int MAX_WINDOW_DEF = 15;

	localparam int PIX_W   = 8;
	localparam int COORD_W = 8;
	localparam int DIM_REG_W = 9;
	localparam int WIN_REG_W = 4;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

	localparam logic [DIM_REG_W-1:0] IMAGE_WIDTH_RST  = 9'd256;
	localparam logic [DIM_REG_W-1:0] IMAGE_HEIGHT_RST = 9'd256;
	localparam logic [WIN_REG_W-1:0] WINDOW_SIZE_RST  = 4'd7;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

endpackage

[rtl/amt_if.sv]
interface amt_req_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [amt_pkg::COORD_W-1:0]   row;
	logic [amt_pkg::COORD_W-1:0]   col;
	logic [amt_pkg::PIX_W-1:0]     pixel;

	modport source (output valid, kind, row, col, pixel, input ready);
	modport sink   (input valid, kind, row, col, pixel, output ready);
endinterface

interface amt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          mark;
	logic [amt_pkg::PIX_W-1:0]     local_mean;
	logic                          out_of_range;

	modport source (output valid, mark, local_mean, out_of_range, input ready);
	modport sink   (input valid, mark, local_mean, out_of_range, output ready);
endinterface

[rtl/amt_ram.sv]
module amt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/adaptive_mean_threshold.sv]
// Adaptive mean threshold over a frame held in one synchronous RAM.
// Write item: stored in the cycle it is accepted; ready stays high for the next item.
// Query item: one RAM read per window pixel (up to 225), one self read,
// then a restoring divide of SUM_W steps.
// Out-of-range query: skips the scan and divide and goes to the result. One item in flight at a time.
// Reset: config registers to 256/256/7, control idle; RAM contents undefined.
module adaptive_mean_threshold #(
	parameter int MAX_WIDTH  = amt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = amt_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_WINDOW = amt_pkg::MAX_WINDOW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [amt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [amt_pkg::CFG_DATA_W-1:0]  cfg_data,
	amt_req_if.sink                         req,
	amt_rsp_if.source                       rsp
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WIN_REG_MAX = (1 << amt_pkg::WIN_REG_W) - 1;
	localparam int EFF_WIN = (MAX_WINDOW < WIN_REG_MAX) ? MAX_WINDOW : WIN_REG_MAX;
	localparam int MAX_CNT = EFF_WIN * EFF_WIN;
	localparam int CNT_W   = $clog2(MAX_CNT + 1);
	localparam int SUM_W   = CNT_W + amt_pkg::PIX_W;
	localparam int DCNT_W  = (SUM_W > 1) ? $clog2(SUM_W) : 1;
	localparam int DW_A    = $clog2(MAX_WIDTH + 1);
	localparam int DW_B    = $clog2(MAX_HEIGHT + 1);
	localparam int DW_AB   = (DW_A > DW_B) ? DW_A : DW_B;
	localparam int DIM_W   = ((DW_AB > amt_pkg::DIM_REG_W) ? DW_AB : amt_pkg::DIM_REG_W) + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_SELF = 3'd2;
	localparam logic [2:0] ST_LOAD = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;

	logic [amt_pkg::DIM_REG_W-1:0] image_width_q, image_height_q;
	logic [amt_pkg::WIN_REG_W-1:0] window_size_q;

	logic [amt_pkg::COORD_W-1:0] row_q, col_q;
	logic [DIM_W-1:0] r_q, c_q, c0_q, r1m1_q, c1m1_q;
	logic [SUM_W-1:0] sum_q, quo_q;
	logic [CNT_W-1:0] cnt_q, rem_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic [amt_pkg::PIX_W-1:0] self_q;
	logic oor_q;
	logic rd_s1;

	logic out_valid_q, mark_q, out_of_range_q;
	logic [amt_pkg::PIX_W-1:0] mean_q;

	// window bounds from current config
	logic [DIM_W-1:0] w_eff, h_eff, row_x, col_x, ws, half, r0, c0, r1, c1;
	logic [amt_pkg::WIN_REG_W-1:0] ws_odd;
	logic accept, is_query, in_range;

	always_comb begin
		w_eff = (DIM_W'(image_width_q) < DIM_W'(MAX_WIDTH)) ?
			DIM_W'(image_width_q) : DIM_W'(MAX_WIDTH);
		h_eff = (DIM_W'(image_height_q) < DIM_W'(MAX_HEIGHT)) ?
			DIM_W'(image_height_q) : DIM_W'(MAX_HEIGHT);
		row_x = DIM_W'(req.row);
		col_x = DIM_W'(req.col);
		// zero -> 1, even -> next odd
		ws_odd = window_size_q | amt_pkg::WIN_REG_W'(1);
		ws = (DIM_W'(ws_odd) < DIM_W'(MAX_WINDOW)) ? DIM_W'(ws_odd) : DIM_W'(MAX_WINDOW);
		half = ws >> 1;
		r0 = (row_x >= half) ? row_x - half : '0;
		c0 = (col_x >= half) ? col_x - half : '0;
		r1 = (h_eff < r0 + ws) ? h_eff : r0 + ws;
		c1 = (w_eff < c0 + ws) ? w_eff : c0 + ws;
		in_range = (row_x < h_eff) && (col_x < w_eff);
	end

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_query  = (req.kind == amt_pkg::KIND_QUERY);

	// RAM ports
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [amt_pkg::PIX_W-1:0] ram_rdata;

	assign ram_we = accept && (req.kind == amt_pkg::KIND_WRITE) &&
		(DIM_W'(req.row) < DIM_W'(MAX_HEIGHT)) && (DIM_W'(req.col) < DIM_W'(MAX_WIDTH));
	assign ram_waddr = AW'(req.row) * AW'(MAX_WIDTH) + AW'(req.col);

	always_comb begin
		if (state_q == ST_SCAN) begin
			ram_raddr = AW'(r_q) * AW'(MAX_WIDTH) + AW'(c_q);
		end else begin
			ram_raddr = AW'(row_q) * AW'(MAX_WIDTH) + AW'(col_q);
		end
	end

	amt_ram #(
		.WIDTH (amt_pkg::PIX_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req.pixel),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// divider step
	logic [CNT_W:0] trial;
	logic           take;
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign take  = (trial >= {1'b0, cnt_q});

	logic load_out;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= amt_pkg::IMAGE_WIDTH_RST;
			image_height_q <= amt_pkg::IMAGE_HEIGHT_RST;
			window_size_q  <= amt_pkg::WINDOW_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				amt_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				amt_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				amt_pkg::REG_WINDOW_SIZE:  window_size_q  <= cfg_data[amt_pkg::WIN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= (state_q == ST_SCAN);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_query) begin
						state_q <= in_range ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (c_q == c1m1_q && r_q == r1m1_q) begin
						state_q <= ST_SELF;
					end
				end
				ST_SELF: state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (rd_s1) begin
			sum_q <= sum_q + SUM_W'(ram_rdata);
			cnt_q <= cnt_q + CNT_W'(1);
		end
		unique case (state_q)
			ST_IDLE: begin
				row_q  <= req.row;
				col_q  <= req.col;
				oor_q  <= !in_range;
				r_q    <= r0;
				c_q    <= c0;
				c0_q   <= c0;
				r1m1_q <= r1 - DIM_W'(1);
				c1m1_q <= c1 - DIM_W'(1);
				sum_q  <= '0;
				cnt_q  <= '0;
			end
			ST_SCAN: begin
				if (c_q == c1m1_q) begin
					c_q <= c0_q;
					r_q <= r_q + DIM_W'(1);
				end else begin
					c_q <= c_q + DIM_W'(1);
				end
			end
			ST_LOAD: begin
				self_q    <= ram_rdata;
				quo_q     <= sum_q;
				rem_q     <= '0;
				div_cnt_q <= DCNT_W'(SUM_W - 1);
			end
			ST_DIV: begin
				rem_q     <= take ? CNT_W'(trial - {1'b0, cnt_q}) : CNT_W'(trial);
				quo_q     <= {quo_q[SUM_W-2:0], take};
				div_cnt_q <= div_cnt_q - DCNT_W'(1);
			end
			default: ;
		endcase
		if (load_out) begin
			out_of_range_q <= oor_q;
			mean_q         <= oor_q ? '0 : quo_q[amt_pkg::PIX_W-1:0];
			mark_q         <= !oor_q && (self_q < quo_q[amt_pkg::PIX_W-1:0]);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.mark         = mark_q;
	assign rsp.local_mean   = mean_q;
	assign rsp.out_of_range = out_of_range_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q != '0 && cnt_q <= CNT_W'(MAX_CNT)))
		else $error("window count out of bounds in divide");

	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (r_q <= r1m1_q && c_q <= c1m1_q))
		else $error("scan address beyond window");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside done state");

	a_mark_oor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_of_range_q) |-> (!mark_q && mean_q == '0))
		else $error("out-of-range result carries data");

	a_no_accum_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_DONE) |-> !rd_s1)
		else $error("pixel accumulate outside scan");

endmodule

[tb/adaptive_mean_threshold_test.sv]
module adaptive_mean_threshold_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [amt_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int IDLE_GAP    = 4;
	localparam int END_WAIT    = 300;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int FRAME_W     = amt_pkg::MAX_WIDTH_DEF;
	localparam int FRAME_H     = amt_pkg::MAX_HEIGHT_DEF;

	typedef struct packed {
		logic                      mark;
		logic [amt_pkg::PIX_W-1:0] local_mean;
		logic                      out_of_range;
	} threshold_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [amt_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [amt_pkg::CFG_DATA_W-1:0] cfg_data;

	amt_req_if req_ch ();
	amt_rsp_if rsp_ch ();

	adaptive_mean_threshold uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// shadow of the frame and of the registers
	logic [amt_pkg::PIX_W-1:0]     frame_mirror [0:FRAME_W*FRAME_H-1];
	bit                            pixel_known  [0:FRAME_W*FRAME_H-1];
	logic [amt_pkg::DIM_REG_W-1:0] img_width;
	logic [amt_pkg::DIM_REG_W-1:0] img_height;
	logic [amt_pkg::WIN_REG_W-1:0] win_raw;

	threshold_result_t pending_marks [$];
	int mismatch_count;
	int cycle_count;
	int burst_left;
	int stall_left;
	bit steady;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int frame_w();
		return (img_width > FRAME_W) ? FRAME_W : int'(img_width);
	endfunction

	function automatic int frame_h();
		return (img_height > FRAME_H) ? FRAME_H : int'(img_height);
	endfunction

	function automatic void window_span(input int row, input int col,
			output int r0, output int r1, output int c0, output int c1);
		int ws;
		int half;
		ws = int'(win_raw);
		if (ws == 0)
			ws = 1;
		if ((ws & 1) == 0)
			ws++;
		if (ws > amt_pkg::MAX_WINDOW_DEF)
			ws = amt_pkg::MAX_WINDOW_DEF;
		half = ws / 2;
		r0 = (row >= half) ? row - half : 0;
		c0 = (col >= half) ? col - half : 0;
		r1 = (frame_h() < r0 + ws) ? frame_h() : r0 + ws;
		c1 = (frame_w() < c0 + ws) ? frame_w() : c0 + ws;
	endfunction

	// every pixel the window reads has been written
	function automatic bit window_ready(int row, int col);
		int r0, r1, c0, c1, r, c;
		window_span(row, col, r0, r1, c0, c1);
		for (r = r0; r < r1; r++)
			for (c = c0; c < c1; c++)
				if (!pixel_known[r * FRAME_W + c])
					return 1'b0;
		return 1'b1;
	endfunction

	function automatic threshold_result_t predict_mark(int row, int col);
		threshold_result_t res;
		int r0, r1, c0, c1, r, c, sum, cnt, mean;
		res = '0;
		if (row >= frame_h() || col >= frame_w()) begin
			res.out_of_range = 1'b1;
			return res;
		end
		window_span(row, col, r0, r1, c0, c1);
		sum = 0;
		cnt = 0;
		for (r = r0; r < r1; r++)
			for (c = c0; c < c1; c++) begin
				sum += int'(frame_mirror[r * FRAME_W + c]);
				cnt++;
			end
		mean = sum / cnt;
		res.local_mean = mean[amt_pkg::PIX_W-1:0];
		res.mark = (int'(frame_mirror[row * FRAME_W + col]) < mean);
		return res;
	endfunction

	function automatic logic [amt_pkg::PIX_W-1:0] pick_pixel();
		unique case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return amt_pkg::PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_item(logic kind, logic [amt_pkg::COORD_W-1:0] row,
			logic [amt_pkg::COORD_W-1:0] col, logic [amt_pkg::PIX_W-1:0] pixel);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.kind  <= kind;
		req_ch.row   <= row;
		req_ch.col   <= col;
		req_ch.pixel <= pixel;
		forever begin
			@(posedge clk);
			if (req_ch.ready)
				break;
		end
		if (kind == amt_pkg::KIND_WRITE) begin
			frame_mirror[int'(row) * FRAME_W + int'(col)] = pixel;
			pixel_known[int'(row) * FRAME_W + int'(col)] = 1'b1;
		end else begin
			pending_marks.insert(pending_marks.size(), predict_mark(int'(row), int'(col)));
		end
	endtask

	task automatic write_px(int row, int col, logic [amt_pkg::PIX_W-1:0] value);
		send_item(amt_pkg::KIND_WRITE, amt_pkg::COORD_W'(row), amt_pkg::COORD_W'(col),
			value);
	endtask

	task automatic query_at(int row, int col);
		send_item(amt_pkg::KIND_QUERY, amt_pkg::COORD_W'(row), amt_pkg::COORD_W'(col),
			amt_pkg::PIX_W'($urandom_range(0, 255)));
	endtask

	// drop valid and wait until the block has nothing left in flight
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_marks.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(negedge clk);
	endtask

	task automatic write_reg(logic [amt_pkg::CFG_IDX_W-1:0] idx,
			logic [amt_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		unique case (idx)
			amt_pkg::REG_IMAGE_WIDTH:  img_width = data;
			amt_pkg::REG_IMAGE_HEIGHT: img_height = data;
			amt_pkg::REG_WINDOW_SIZE:  win_raw = data[amt_pkg::WIN_REG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(int w, int h, logic [amt_pkg::WIN_REG_W-1:0] win);
		logic [amt_pkg::CFG_DATA_W-1:0] wdata;
		settle();
		write_reg(amt_pkg::REG_IMAGE_WIDTH, amt_pkg::CFG_DATA_W'(w));
		write_reg(amt_pkg::REG_IMAGE_HEIGHT, amt_pkg::CFG_DATA_W'(h));
		// upper bits of the window register are don't-care
		wdata = amt_pkg::CFG_DATA_W'($urandom_range(0, 511));
		wdata[amt_pkg::WIN_REG_W-1:0] = win;
		write_reg(amt_pkg::REG_WINDOW_SIZE, wdata);
	endtask

	task automatic fill_rect(int r0, int c0, int nr, int nc);
		int r, c;
		for (r = r0; r < r0 + nr; r++)
			for (c = c0; c < c0 + nc; c++)
				write_px(r, c, pick_pixel());
	endtask

	// random writes and queries around a fully written box
	task automatic mixed_ops(int rlo, int rhi, int clo, int chi, int n);
		int k, sel, tries, r, c;
		for (k = 0; k < n; k++) begin
			sel = $urandom_range(0, 19);
			if (sel < 5) begin
				write_px($urandom_range(rlo, rhi), $urandom_range(clo, chi), pick_pixel());
			end else if (sel == 5) begin
				write_px($urandom_range(0, 255), $urandom_range(0, 255), pick_pixel());
			end else if (sel < 8 && (frame_w() < FRAME_W || frame_h() < FRAME_H)) begin
				if (frame_h() < FRAME_H &&
						(frame_w() == FRAME_W || $urandom_range(0, 1) == 1)) begin
					r = $urandom_range(frame_h(), 255);
					c = $urandom_range(0, 255);
				end else begin
					r = $urandom_range(0, 255);
					c = $urandom_range(frame_w(), 255);
				end
				query_at(r, c);
			end else begin
				tries = 0;
				do begin
					r = $urandom_range(rlo, rhi);
					c = $urandom_range(clo, chi);
					tries++;
				end while (!window_ready(r, c) && tries < 40);
				if (window_ready(r, c))
					query_at(r, c);
			end
		end
	endtask

	task automatic test_reset_defaults();
		int r, c;
		// default window of 7 at the far corner clips to rows/cols 252..255
		for (r = 252; r < 256; r++)
			for (c = 252; c < 256; c++)
				write_px(r, c, (r == 255 && c == 255) ? 8'd0 : 8'd255);
		query_at(255, 255);
		settle();
		// unused index must leave every register alone
		write_reg(REG_UNUSED, '1);
		query_at(255, 255);
	endtask

	task automatic test_tiny_frame();
		configure(3, 2, 4'd2);
		write_px(0, 0, 8'd0);
		write_px(0, 1, 8'd255);
		write_px(0, 2, 8'd17);
		write_px(1, 0, 8'd200);
		write_px(1, 1, 8'd1);
		write_px(1, 2, 8'd254);
		query_at(0, 0);
		query_at(1, 2);
		query_at(2, 0);
		query_at(255, 255);
		configure(3, 2, 4'd0);
		query_at(1, 1);
		configure(3, 2, 4'd15);
		query_at(0, 0);
	endtask

	task automatic test_odd_dimensions();
		configure(0, 2, 4'd7);
		query_at(0, 0);
		configure(3, 0, 4'd7);
		write_px(1, 1, 8'd99);
		query_at(0, 0);
		// oversized dimensions saturate to the full frame
		configure(511, 300, 4'd4);
		query_at(255, 255);
		query_at(254, 254);
	endtask

	task automatic test_small_frames();
		int k, w, h;
		logic [amt_pkg::WIN_REG_W-1:0] win;
		for (k = 0; k < 6; k++) begin
			unique case (k)
				0: begin
					w = 1;
					h = 1;
					win = amt_pkg::WIN_REG_W'($urandom_range(0, 15));
				end
				1: begin
					w = 12;
					h = 12;
					win = 4'd15;
				end
				default: begin
					w = $urandom_range(1, 12);
					h = $urandom_range(1, 12);
					win = amt_pkg::WIN_REG_W'($urandom_range(0, 15));
				end
			endcase
			configure(w, h, win);
			steady = (k % 3 == 2);
			fill_rect(0, 0, h, w);
			mixed_ops(0, h - 1, 0, w - 1, 80);
			steady = 1'b0;
		end
	endtask

	task automatic test_strips();
		int first;
		configure(256, 1, amt_pkg::WIN_REG_W'($urandom_range(0, 15)));
		first = $urandom_range(0, 216);
		fill_rect(0, first, 1, 40);
		mixed_ops(0, 0, first, first + 39, 20);
		configure(1, 256, amt_pkg::WIN_REG_W'($urandom_range(0, 15)));
		first = $urandom_range(0, 216);
		fill_rect(first, 0, 40, 1);
		mixed_ops(first, first + 39, 0, 0, 20);
	endtask

	task automatic test_full_frame();
		int k, r0, c0;
		for (k = 0; k < 3; k++) begin
			unique case (k)
				0: begin
					configure(256, 256, amt_pkg::WIN_REG_W'($urandom_range(0, 8)));
					r0 = 0;
					c0 = 0;
				end
				1: begin
					configure(511, 300, amt_pkg::WIN_REG_W'($urandom_range(0, 8)));
					r0 = 246;
					c0 = 246;
				end
				default: begin
					configure(300, 257, amt_pkg::WIN_REG_W'($urandom_range(0, 8)));
					r0 = $urandom_range(0, 246);
					c0 = $urandom_range(0, 246);
				end
			endcase
			fill_rect(r0, c0, 10, 10);
			mixed_ops(r0, r0 + 9, c0, c0 + 9, 15);
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left != 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				// stalls come and go with bit 10 of the cycle counter
				if (cycle_count[10] && $urandom_range(0, 3) == 0)
					stall_left = $urandom_range(1, 12);
			end
		end
	end

	always @(posedge clk) begin : check_results
		threshold_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_marks.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: mark %0d mean %0d out_of_range %0d",
						rsp_ch.mark, rsp_ch.local_mean, rsp_ch.out_of_range);
			end else begin
				want = pending_marks.pop_front();
				if (rsp_ch.mark !== want.mark || rsp_ch.local_mean !== want.local_mean ||
						rsp_ch.out_of_range !== want.out_of_range) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected mark %0d mean %0d oor %0d, got %0d %0d %0d",
							want.mark, want.local_mean, want.out_of_range,
							rsp_ch.mark, rsp_ch.local_mean, rsp_ch.out_of_range);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL adaptive_mean_threshold");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = amt_pkg::REG_IMAGE_WIDTH;
		cfg_data     = '0;
		req_ch.valid = 1'b0;
		req_ch.kind  = amt_pkg::KIND_WRITE;
		req_ch.row   = '0;
		req_ch.col   = '0;
		req_ch.pixel = '0;
		rsp_ch.ready = 1'b0;
		img_width    = amt_pkg::IMAGE_WIDTH_RST;
		img_height   = amt_pkg::IMAGE_HEIGHT_RST;
		win_raw      = amt_pkg::WINDOW_SIZE_RST;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_tiny_frame();
		test_odd_dimensions();
		test_small_frames();
		test_strips();
		test_full_frame();

		settle();
		repeat (END_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS adaptive_mean_threshold");
		else
			$display("FAIL adaptive_mean_threshold");
		$finish;
	end

endmodule
